>>> rtl/core/gbrb_pkg.sv
// gbrb_pkg: constants, address codes and the pin store request type of the
// gpio bank register block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbrb_pkg;

	localparam int BANK0_PINS = 28;
	localparam int TOTAL_PINS = 54;
	localparam int BANK1_RAW  = (TOTAL_PINS > BANK0_PINS) ? TOTAL_PINS - BANK0_PINS : 0;
	localparam int BANK1_PINS = (BANK1_RAW > 32) ? 32 : BANK1_RAW;
	localparam int IDX_W      = $clog2(TOTAL_PINS);
	localparam int PAD_W      = 8;

	localparam logic [31:0] BANK0_MASK = 32'((64'd1 << BANK0_PINS) - 64'd1);
	localparam logic [31:0] BANK1_MASK = 32'((64'd1 << BANK1_PINS) - 64'd1);
	localparam logic [31:0] CTRL_RESET = 32'h0000_001F;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// address bits 17:15
	localparam logic [2:0] REGION_IO   = 3'b000;
	localparam logic [2:0] REGION_RIO  = 3'b010;
	localparam logic [2:0] REGION_PADS = 3'b100;

	// rio word offset, address bits 11:2
	localparam logic [9:0] RIO_OUT = 10'd0;
	localparam logic [9:0] RIO_OE  = 10'd1;
	localparam logic [9:0] RIO_IN  = 10'd2;

	localparam logic [1:0] ALIAS_PLAIN = 2'd0;
	localparam logic [1:0] ALIAS_XOR   = 2'd1;
	localparam logic [1:0] ALIAS_SET   = 2'd2;
	localparam logic [1:0] ALIAS_CLR   = 2'd3;

	typedef struct packed {
		logic             ctrl_we;
		logic             ctrl_re;
		logic             pad_we;
		logic             pad_re;
		logic [IDX_W-1:0] idx;
		logic [31:0]      wdata;
	} pin_req_t;

endpackage

`default_nettype wire

>>> rtl/core/gbrb_req_if.sv
// gbrb_req_if: access channel of the gpio bank register block
// depends on gbrb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gbrb_req_if;
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic [17:0]                     address;
	logic [31:0]                     write_data;
	logic [gbrb_pkg::TOTAL_PINS-1:0] pin_levels;

	modport source (output valid, output opcode, output address, output write_data,
		output pin_levels, input ready);
	modport sink (input valid, input opcode, input address, input write_data,
		input pin_levels, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gbrb_rsp_if.sv
// gbrb_rsp_if: result channel of the gpio bank register block
// depends on gbrb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gbrb_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [31:0]                     read_data;
	logic                            access_error;
	logic [gbrb_pkg::TOTAL_PINS-1:0] out_levels;
	logic [gbrb_pkg::TOTAL_PINS-1:0] drive_enables;

	modport source (output valid, output read_data, output access_error,
		output out_levels, output drive_enables, input ready);
	modport sink (input valid, input read_data, input access_error,
		input out_levels, input drive_enables, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gbrb_pin_mem.sv
// gbrb_pin_mem: per-pin ctrl and pad word memories with a registered read and
// valid bits so unwritten entries read their reset value. depends on gbrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbrb_pin_mem (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gbrb_pkg::pin_req_t req,
	output logic [31:0]             ctrl_rdata,
	output logic [gbrb_pkg::PAD_W-1:0] pad_rdata
);

	logic [31:0]                     ctrl_mem [gbrb_pkg::TOTAL_PINS];
	logic [gbrb_pkg::PAD_W-1:0]      pad_mem  [gbrb_pkg::TOTAL_PINS];
	logic [gbrb_pkg::TOTAL_PINS-1:0] ctrl_vld_q;
	logic [gbrb_pkg::TOTAL_PINS-1:0] pad_vld_q;
	logic [31:0]                     ctrl_rd_q;
	logic [gbrb_pkg::PAD_W-1:0]      pad_rd_q;
	logic                            ctrl_rdv_q;
	logic                            pad_rdv_q;

	always_ff @(posedge clk) begin
		if (req.ctrl_we) begin
			ctrl_mem[req.idx] <= req.wdata;
		end
		if (req.pad_we) begin
			pad_mem[req.idx] <= req.wdata[gbrb_pkg::PAD_W-1:0];
		end
		if (req.ctrl_re) begin
			ctrl_rd_q <= ctrl_mem[req.idx];
		end
		if (req.pad_re) begin
			pad_rd_q <= pad_mem[req.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_vld_q <= '0;
			pad_vld_q  <= '0;
			ctrl_rdv_q <= 1'b0;
			pad_rdv_q  <= 1'b0;
		end else begin
			if (req.ctrl_we) begin
				ctrl_vld_q[req.idx] <= 1'b1;
			end
			if (req.pad_we) begin
				pad_vld_q[req.idx] <= 1'b1;
			end
			if (req.ctrl_re) begin
				ctrl_rdv_q <= ctrl_vld_q[req.idx];
			end
			if (req.pad_re) begin
				pad_rdv_q <= pad_vld_q[req.idx];
			end
		end
	end

	assign ctrl_rdata = ctrl_rdv_q ? ctrl_rd_q : gbrb_pkg::CTRL_RESET;
	assign pad_rdata  = pad_rdv_q ? pad_rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/core/gpio_bank_register_block.sv
// gpio_bank_register_block: two-bank gpio register block top level
// depends on gbrb_pkg, gbrb_req_if, gbrb_rsp_if, gbrb_pin_mem
//
//   channel  dir  words
//   req      in   opcode, address, write_data, pin_levels
//   rsp      out  read_data, access_error, out_levels, drive_enables
//
// one access accepted per cycle while no result word waits or rsp is ready;
// its result word is registered, with ctrl / pad words from the memories' registered read.
// reset clears out and oe registers and the memory valid bits, so ctrl words
// read funcsel 31 and pad words read zero until written; no clearing pass.
// req stalls only while a result word waits on rsp.
`timescale 1ns / 1ps
`default_nettype none

module gpio_bank_register_block (
	input wire logic  clk,
	input wire logic  arst_n,
	gbrb_req_if.sink   req,
	gbrb_rsp_if.source rsp
);

	localparam logic [1:0] SRC_DIRECT = 2'd0;
	localparam logic [1:0] SRC_CTRL   = 2'd1;
	localparam logic [1:0] SRC_PAD    = 2'd2;

	function automatic logic [31:0] apply_alias(input logic [31:0] cur,
		input logic [31:0] wdata, input logic [1:0] sel, input logic [31:0] mask);
		logic [31:0] v;
		case (sel)
			gbrb_pkg::ALIAS_PLAIN: v = wdata;
			gbrb_pkg::ALIAS_XOR:   v = cur ^ wdata;
			gbrb_pkg::ALIAS_SET:   v = cur | wdata;
			default:               v = cur & ~wdata;
		endcase
		return v & mask;
	endfunction

	function automatic logic [gbrb_pkg::TOTAL_PINS-1:0] join_banks(input logic [31:0] b0,
		input logic [31:0] b1);
		logic [63:0] v;
		v = 64'(b0 & gbrb_pkg::BANK0_MASK)
			| (64'(b1 & gbrb_pkg::BANK1_MASK) << gbrb_pkg::BANK0_PINS);
		return v[gbrb_pkg::TOTAL_PINS-1:0];
	endfunction

	logic [31:0] out0_q, out1_q, oe0_q, oe1_q;
	logic [31:0] out0_d, out1_d, oe0_d, oe1_d;

	logic                            vld_s1;
	logic [1:0]                      src_s1;
	logic                            err_s1;
	logic [31:0]                     rdd_s1;
	logic [gbrb_pkg::TOTAL_PINS-1:0] lv_s1;
	logic [gbrb_pkg::TOTAL_PINS-1:0] oe_s1;

	gbrb_pkg::pin_req_t         mreq;
	logic [31:0]                ctrl_rdata;
	logic [gbrb_pkg::PAD_W-1:0] pad_rdata;

	logic        acc;
	logic        wr;
	logic [2:0]  region;
	logic        bank;
	logic [10:0] io_pin;
	logic [11:0] pad_off;
	logic [11:0] pad_pin;
	logic [1:0]  alias_sel;
	logic [9:0]  rio_reg;
	logic [6:0]  bank_cnt;
	logic [31:0] mask;
	logic [63:0] lv_shift;
	logic        err;
	logic [1:0]  src;
	logic [31:0] rdd;
	logic [31:0] cur;

	assign req.ready = !vld_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign wr        = req.opcode == gbrb_pkg::OP_WRITE;
	assign region    = req.address[17:15];
	assign bank      = req.address[14];
	assign io_pin    = req.address[13:3];
	assign pad_off   = req.address[13:2];
	assign pad_pin   = pad_off - 12'd1;
	assign alias_sel = req.address[13:12];
	assign rio_reg   = req.address[11:2];
	assign bank_cnt  = bank ? 7'(gbrb_pkg::BANK1_PINS) : 7'(gbrb_pkg::BANK0_PINS);
	assign mask      = bank ? gbrb_pkg::BANK1_MASK : gbrb_pkg::BANK0_MASK;
	assign lv_shift  = bank ? (64'(req.pin_levels) >> gbrb_pkg::BANK0_PINS)
		: 64'(req.pin_levels);

	always_comb begin
		mreq   = '0;
		err    = 1'b0;
		src    = SRC_DIRECT;
		rdd    = '0;
		out0_d = out0_q;
		out1_d = out1_q;
		oe0_d  = oe0_q;
		oe1_d  = oe1_q;
		cur    = '0;
		mreq.wdata = req.write_data;
		unique case (region)
			gbrb_pkg::REGION_IO: begin
				if (io_pin >= 11'(bank_cnt)) begin
					err = 1'b1;
				end else if (req.address[2]) begin
					mreq.idx = bank
						? gbrb_pkg::IDX_W'(gbrb_pkg::BANK0_PINS) + io_pin[gbrb_pkg::IDX_W-1:0]
						: io_pin[gbrb_pkg::IDX_W-1:0];
					if (wr) begin
						mreq.ctrl_we = acc;
					end else begin
						mreq.ctrl_re = acc;
						src = SRC_CTRL;
					end
				end
			end
			gbrb_pkg::REGION_RIO: begin
				unique case (rio_reg) inside
					gbrb_pkg::RIO_OUT, gbrb_pkg::RIO_OE: begin
						if (rio_reg == gbrb_pkg::RIO_OUT) begin
							cur = bank ? out1_q : out0_q;
						end else begin
							cur = bank ? oe1_q : oe0_q;
						end
						if (wr) begin
							if (rio_reg == gbrb_pkg::RIO_OUT && !bank) begin
								out0_d = apply_alias(cur, req.write_data, alias_sel, mask);
							end else if (rio_reg == gbrb_pkg::RIO_OUT) begin
								out1_d = apply_alias(cur, req.write_data, alias_sel, mask);
							end else if (!bank) begin
								oe0_d = apply_alias(cur, req.write_data, alias_sel, mask);
							end else begin
								oe1_d = apply_alias(cur, req.write_data, alias_sel, mask);
							end
						end else begin
							rdd = cur & mask;
						end
					end
					gbrb_pkg::RIO_IN: begin
						if (!wr) begin
							rdd = lv_shift[31:0] & mask;
						end
					end
					default: begin
						err = 1'b1;
					end
				endcase
			end
			gbrb_pkg::REGION_PADS: begin
				if (pad_off == 12'd0 || pad_pin >= 12'(bank_cnt)) begin
					err = 1'b1;
				end else begin
					mreq.idx = bank
						? gbrb_pkg::IDX_W'(gbrb_pkg::BANK0_PINS) + pad_pin[gbrb_pkg::IDX_W-1:0]
						: pad_pin[gbrb_pkg::IDX_W-1:0];
					if (wr) begin
						mreq.pad_we = acc;
					end else begin
						mreq.pad_re = acc;
						src = SRC_PAD;
					end
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	gbrb_pin_mem u_pin_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (mreq),
		.ctrl_rdata (ctrl_rdata),
		.pad_rdata  (pad_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out0_q <= '0;
			out1_q <= '0;
			oe0_q  <= '0;
			oe1_q  <= '0;
			vld_s1 <= 1'b0;
			src_s1 <= SRC_DIRECT;
		end else begin
			if (acc) begin
				out0_q <= out0_d;
				out1_q <= out1_d;
				oe0_q  <= oe0_d;
				oe1_q  <= oe1_d;
				vld_s1 <= 1'b1;
				src_s1 <= src;
			end else if (rsp.ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			err_s1 <= err;
			rdd_s1 <= rdd;
			lv_s1  <= join_banks(out0_d, out1_d);
			oe_s1  <= join_banks(oe0_d, oe1_d);
		end
	end

	always_comb begin
		case (src_s1)
			SRC_CTRL: rsp.read_data = ctrl_rdata;
			SRC_PAD:  rsp.read_data = {{(32 - gbrb_pkg::PAD_W){1'b0}}, pad_rdata};
			default:  rsp.read_data = rdd_s1;
		endcase
	end

	assign rsp.valid         = vld_s1;
	assign rsp.access_error  = err_s1;
	assign rsp.out_levels    = lv_s1;
	assign rsp.drive_enables = oe_s1;

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("req accepted while result word stalled");

	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.access_error) |-> (rsp.read_data == 32'd0))
		else $error("error word carries nonzero read data");

	a_write_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode == gbrb_pkg::OP_WRITE)
		|=> (rsp.valid && rsp.read_data == 32'd0))
		else $error("write result missing or carries read data");

	a_read_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		(acc) |-> $onehot0({mreq.ctrl_re, mreq.ctrl_we, mreq.pad_re, mreq.pad_we}))
		else $error("more than one pin memory access for one word");

endmodule

`default_nettype wire

>>> dv/gbrb_access_checker.sv
// gbrb_access_checker: watches the req and rsp channels of the gpio bank register block,
// predicts every result word and compares it field by field
// depends on gbrb_pkg, gbrb_req_if, gbrb_rsp_if
`timescale 1ns / 1ps

module gbrb_access_checker
	import gbrb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	gbrb_req_if   req,
	gbrb_rsp_if   rsp,
	output int    fail_count,
	output int    pending_results
);

	typedef struct packed {
		logic [31:0]           read_data;
		logic                  access_error;
		logic [TOTAL_PINS-1:0] out_levels;
		logic [TOTAL_PINS-1:0] drive_enables;
	} access_result_t;

	logic [31:0] out_bank [2];
	logic [31:0] oe_bank [2];
	logic [31:0] ctrl_words [TOTAL_PINS];
	logic [PAD_W-1:0] pad_words [TOTAL_PINS];
	access_result_t expected_results [$];
	access_result_t want;

	function automatic logic [TOTAL_PINS-1:0] join_banks(input logic [31:0] lo,
		input logic [31:0] hi);
		logic [63:0] both;
		both = {32'd0, lo & BANK0_MASK} | ({32'd0, hi & BANK1_MASK} << BANK0_PINS);
		return both[TOTAL_PINS-1:0];
	endfunction

	function automatic access_result_t apply_access(input logic op, input logic [17:0] a,
		input logic [31:0] wd, input logic [TOTAL_PINS-1:0] lv);
		access_result_t r;
		logic bank;
		logic [31:0] mask;
		logic [31:0] cur;
		logic [63:0] lv64;
		int unsigned count;
		int unsigned pin;
		int unsigned idx;
		r = '0;
		bank = a[14];
		count = bank ? BANK1_PINS : BANK0_PINS;
		mask = bank ? BANK1_MASK : BANK0_MASK;
		lv64 = 64'(lv);
		case (a[17:15])
			REGION_IO: begin
				pin = a[13:3];
				if (pin >= count) begin
					r.access_error = 1'b1;
				end else if (a[2]) begin
					idx = bank ? BANK0_PINS + pin : pin;
					if (op == OP_WRITE) ctrl_words[idx] = wd;
					else r.read_data = ctrl_words[idx];
				end
			end
			REGION_RIO: begin
				if (a[11:2] == RIO_OUT || a[11:2] == RIO_OE) begin
					cur = (a[11:2] == RIO_OUT) ? out_bank[bank] : oe_bank[bank];
					if (op == OP_WRITE) begin
						case (a[13:12])
							ALIAS_PLAIN: cur = wd;
							ALIAS_XOR:   cur = cur ^ wd;
							ALIAS_SET:   cur = cur | wd;
							default:     cur = cur & ~wd;
						endcase
						cur = cur & mask;
						if (a[11:2] == RIO_OUT) out_bank[bank] = cur;
						else oe_bank[bank] = cur;
					end else begin
						r.read_data = cur & mask;
					end
				end else if (a[11:2] == RIO_IN) begin
					if (op != OP_WRITE)
						r.read_data = (bank ? 32'(lv64 >> BANK0_PINS) : lv64[31:0]) & mask;
				end else begin
					r.access_error = 1'b1;
				end
			end
			REGION_PADS: begin
				if (a[13:2] == 12'd0 || int'(a[13:2]) - 1 >= int'(count)) begin
					r.access_error = 1'b1;
				end else begin
					pin = int'(a[13:2]) - 1;
					idx = bank ? BANK0_PINS + pin : pin;
					if (op == OP_WRITE) pad_words[idx] = wd[PAD_W-1:0];
					else r.read_data = 32'(pad_words[idx]);
				end
			end
			default: begin
				r.access_error = 1'b1;
			end
		endcase
		if (op == OP_WRITE || r.access_error) r.read_data = '0;
		r.out_levels = join_banks(out_bank[0], out_bank[1]);
		r.drive_enables = join_banks(oe_bank[0], oe_bank[1]);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] exp_val,
		input logic [63:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t ns: %s expected %h, got %h", $time, field, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bank[0] = '0;
			out_bank[1] = '0;
			oe_bank[0] = '0;
			oe_bank[1] = '0;
			for (int i = 0; i < TOTAL_PINS; i++) begin
				ctrl_words[i] = CTRL_RESET;
				pad_words[i] = '0;
			end
			expected_results.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result word with nothing expected, read_data %h",
						$time, rsp.read_data);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("read_data", 64'(want.read_data), 64'(rsp.read_data));
					compare_field("access_error", 64'(want.access_error),
						64'(rsp.access_error));
					compare_field("out_levels", 64'(want.out_levels), 64'(rsp.out_levels));
					compare_field("drive_enables", 64'(want.drive_enables),
						64'(rsp.drive_enables));
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(apply_access(req.opcode, req.address,
					req.write_data, req.pin_levels));
			pending_results = expected_results.size();
		end
	end

endmodule

>>> dv/gpio_bank_register_block_test.sv
// gpio_bank_register_block_test: drives bus accesses into the gpio bank register block
// with random stalls on both channels and gives the verdict
// depends on gbrb_pkg, gbrb_req_if, gbrb_rsp_if, gpio_bank_register_block, gbrb_access_checker
`timescale 1ns / 1ps

module gpio_bank_register_block_test;
	import gbrb_pkg::*;

	localparam int ITEM_COUNT  = 750;
	localparam int CALM_TAIL   = 100;
	localparam int STALL_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit source_idle;
	bit sink_idle;
	int fail_count;
	int pending_results;
	int quiet_cycles = 0;

	gbrb_req_if req_ch ();
	gbrb_rsp_if rsp_ch ();

	gpio_bank_register_block dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	gbrb_access_checker access_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_idle && $urandom_range(0, 6) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic logic [17:0] io_addr(input logic bank, input int pin, input logic ctrl);
		return {REGION_IO, bank, 11'(pin), ctrl, 2'b00};
	endfunction

	function automatic logic [17:0] rio_addr(input logic bank, input logic [1:0] alias_sel,
		input logic [9:0] word);
		return {REGION_RIO, bank, alias_sel, word, 2'b00};
	endfunction

	// slot 0 is the unmapped word below the first pad
	function automatic logic [17:0] pad_addr(input logic bank, input int slot);
		return {REGION_PADS, bank, 12'(slot), 2'b00};
	endfunction

	task automatic send_access(input logic op, input logic [17:0] a, input logic [31:0] wd,
		input logic [TOTAL_PINS-1:0] lv);
		if (source_idle && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.address <= a;
		req_ch.write_data <= wd;
		req_ch.pin_levels <= lv;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
	endtask

	task automatic send_random_access();
		logic op;
		logic bank;
		logic [1:0] alias_sel;
		logic [9:0] word;
		logic [17:0] a;
		logic [31:0] wd;
		logic [TOTAL_PINS-1:0] lv;
		int count;
		int kind;
		op = 1'($urandom_range(0, 1));
		bank = 1'($urandom_range(0, 1));
		alias_sel = 2'($urandom_range(0, 3));
		count = bank ? BANK1_PINS : BANK0_PINS;
		lv = TOTAL_PINS'({$urandom, $urandom});
		case ($urandom_range(0, 7))
			0: wd = '0;
			1: wd = '1;
			default: wd = $urandom;
		endcase
		case ($urandom_range(0, 2))
			0: word = RIO_OUT;
			1: word = RIO_OE;
			default: word = RIO_IN;
		endcase
		kind = $urandom_range(0, 99);
		if (kind < 30) a = io_addr(bank, $urandom_range(0, count - 1), $urandom_range(0, 3) != 0);
		else if (kind < 60) a = rio_addr(bank, alias_sel, word);
		else if (kind < 80) a = pad_addr(bank, $urandom_range(1, count));
		else if (kind < 85) a = io_addr(bank, $urandom_range(count, 2047), 1'($urandom));
		else if (kind < 89) a = rio_addr(bank, alias_sel, 10'($urandom_range(3, 1023)));
		else if (kind < 93)
			a = pad_addr(bank, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(count + 1, 4095));
		else a = 18'($urandom_range(0, 32'h2FFFF));
		a[1:0] = 2'($urandom);
		send_access(op, a, wd, lv);
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_READ;
		req_ch.address = '0;
		req_ch.write_data = '0;
		req_ch.pin_levels = '0;
		source_idle = 1'b1;
		sink_idle = 1'b1;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values, aliases, extremes and unmapped holes
		send_access(OP_READ, io_addr(1'b0, 0, 1'b1), '1, '0);
		send_access(OP_READ, pad_addr(1'b1, BANK1_PINS), '0, '1);
		send_access(OP_WRITE, rio_addr(1'b0, ALIAS_PLAIN, RIO_OUT), '1, '0);
		send_access(OP_WRITE, rio_addr(1'b1, ALIAS_XOR, RIO_OUT), '1, '1);
		send_access(OP_WRITE, rio_addr(1'b0, ALIAS_SET, RIO_OE), 32'hA5A5_A5A5, '0);
		send_access(OP_WRITE, rio_addr(1'b1, ALIAS_CLR, RIO_OE), 32'hFFFF_0000, '0);
		send_access(OP_WRITE, rio_addr(1'b1, ALIAS_SET, RIO_OE), '1, '0);
		send_access(OP_READ, rio_addr(1'b0, ALIAS_SET, RIO_OUT), '0, '0);
		send_access(OP_READ, rio_addr(1'b1, ALIAS_CLR, RIO_OE), '0, '0);
		send_access(OP_READ, rio_addr(1'b0, ALIAS_PLAIN, RIO_IN), '0, '1);
		send_access(OP_READ, rio_addr(1'b1, ALIAS_XOR, RIO_IN), '0,
			TOTAL_PINS'(64'h0015_5555_AAAA_AAAA));
		send_access(OP_WRITE, rio_addr(1'b0, ALIAS_PLAIN, RIO_IN), '1, '1);
		send_access(OP_WRITE, io_addr(1'b0, BANK0_PINS - 1, 1'b1), '1, '0);
		send_access(OP_READ, io_addr(1'b0, BANK0_PINS - 1, 1'b1), '0, '0);
		send_access(OP_WRITE, io_addr(1'b1, BANK1_PINS - 1, 1'b1), 32'h0000_F01E, '0);
		send_access(OP_READ, io_addr(1'b1, BANK1_PINS - 1, 1'b1) | 18'd3, '0, '0);
		send_access(OP_WRITE, io_addr(1'b0, 0, 1'b0), '1, '0);
		send_access(OP_READ, io_addr(1'b0, 0, 1'b0), '0, '0);
		send_access(OP_WRITE, pad_addr(1'b0, 1), 32'hFFFF_FF5A, '0);
		send_access(OP_READ, pad_addr(1'b0, 1), '0, '0);
		send_access(OP_WRITE, pad_addr(1'b1, 0), '1, '0);
		send_access(OP_READ, io_addr(1'b0, BANK0_PINS, 1'b1), '0, '0);
		send_access(OP_WRITE, io_addr(1'b1, BANK1_PINS, 1'b1), '1, '0);
		send_access(OP_WRITE, rio_addr(1'b0, ALIAS_PLAIN, 10'h3FF), '1, '0);
		send_access(OP_READ, 18'h0_8000, '0, '0);
		send_access(OP_READ, 18'h2_FFFC, '0, '0);
		send_access(OP_WRITE, rio_addr(1'b0, ALIAS_CLR, RIO_OUT), '1, '0);
		drain_results();

		for (int n = 0; n < ITEM_COUNT; n++) begin
			if (n % 50 == 0) begin
				source_idle = $urandom_range(0, 3) != 0;
				sink_idle = $urandom_range(0, 3) != 0;
				if ($urandom_range(0, 2) == 0) drain_results();
			end
			if (n >= ITEM_COUNT - CALM_TAIL) begin
				source_idle = 1'b0;
				sink_idle = 1'b0;
			end
			send_random_access();
		end

		drain_results();
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
